// ===== src/assert_macros.svh =====
// assertion macros for the balance controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BCC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("balance controller assertion failed");
`define BCC_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("balance controller assertion failed");
`else
`define BCC_ASSERT(lbl, clk, rstn, prop)
`define BCC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== src/bcc_pkg.sv =====
// types and constants of the balance cascade controller
`timescale 1ns / 1ps
package bcc_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX,
        S_DIV,
        S_DIVFIX,
        S_FILT,
        S_PKP,
        S_PKI,
        S_PSUM,
        S_PSAT,
        S_UERR,
        S_UKP,
        S_UKD,
        S_USUM,
        S_DRV
    } t_state;

    localparam int unsigned DRIVE_LIMIT_DEF    = 7200;
    localparam int unsigned INTEGRAL_LIMIT_DEF = 10000;
    localparam int unsigned SECOND_OFFSET_DEF  = 120;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_ANGLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI     = 3'd5;

    // floor(2^24 / 10), quotient estimate is exact or one low
    localparam logic [20:0] DIV10_RECIP = 21'd1677721;

    localparam int IN_W  = 72;
    localparam int OUT_W = 48;

endpackage

// ===== src/balance_cascade_control.sv =====
// balance cascade controller: speed pi loop feeding an upright pd loop
// usage:
//   s_axis carries one control tick (tilt angle, gyro rate, wheel speeds);
//   m_axis returns one item per tick: two pwm duties, direction, speed output.
//   cfg channel writes the six gain and setpoint registers, always ready;
//   write only while no tick is in flight.
// sequencing:
//   a tick is taken only when the sequencer is idle; one shared 26x22
//   multiplier and a short chain of add/compare steps then compute it, so
//   a new tick is not taken until the previous one leaves the sequencer.
// stalls:
//   a finished item waits in the output register; the next tick is accepted
//   and computed meanwhile, and holds in its last step until the output
//   register frees.
// reset:
//   synchronous active low i_rst_n clears the state, configuration, filter
//   and integral registers, and drops the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module balance_cascade_control
    import bcc_pkg::*;
#(
    parameter int unsigned DRIVE_LIMIT    = DRIVE_LIMIT_DEF,
    parameter int unsigned INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int unsigned SECOND_OFFSET  = SECOND_OFFSET_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tilt_angle[16:0] tilt_rate[32:17] left_speed[48:33] right_speed[64:49]
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // duty_first[12:0] duty_second[25:13] reverse_dir[26] speed_loop_out[42:27]
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [18:0] ILIM     = 19'(INTEGRAL_LIMIT);
    localparam logic signed [18:0] ILIM_NEG = -ILIM;
    localparam logic signed [40:0] DLIM     = 41'(DRIVE_LIMIT);
    localparam logic signed [40:0] SAT_HI   = 41'sd32767;
    localparam logic signed [40:0] SAT_LO   = -41'sd32767;

    t_state r_state, n_state;

    logic signed [15:0] r_target_speed;
    logic signed [7:0]  r_mid_angle;
    logic signed [12:0] r_upright_kp;
    logic signed [15:0] r_upright_kd;
    logic signed [15:0] r_speed_kp;
    logic signed [15:0] r_speed_ki;

    logic signed [17:0] r_filt;
    logic signed [14:0] r_integ;

    logic signed [16:0] r_angle;
    logic signed [15:0] r_rate;
    logic signed [17:0] r_err;
    logic               r_mix_neg;
    logic [20:0]        r_mix_abs;
    logic [17:0]        r_quo;
    logic signed [47:0] r_prod;
    logic signed [40:0] r_acc;
    logic signed [15:0] r_spout;
    logic signed [25:0] r_aerr;

    logic               r_out_valid;
    logic [12:0]        r_duty1;
    logic [12:0]        r_duty2;
    logic               r_dir;
    logic [15:0]        r_out_spout;

    logic signed [16:0] in_angle;
    logic signed [15:0] in_rate;
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;
    logic               in_acc;
    logic               out_free;

    logic signed [17:0] err_sum;
    logic signed [21:0] e22, f22, mix, mix_neg, mix_abs;
    logic [17:0]        quo_est;
    logic [21:0]        quo10, rem;
    logic signed [18:0] fq, fv;
    logic signed [18:0] integ_sum, r_integ_ext;
    logic signed [25:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [40:0] acc_adj, acc_q, mag_w, mag_c;
    logic signed [15:0] spout_c;
    logic signed [16:0] sp17;
    logic signed [25:0] aerr;
    logic [16:0]        duty2_sum;

    assign in_angle = $signed(i_s_axis_tdata[16:0]);
    assign in_rate  = $signed(i_s_axis_tdata[32:17]);
    assign in_left  = $signed(i_s_axis_tdata[48:33]);
    assign in_right = $signed(i_s_axis_tdata[64:49]);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_spout, r_dir, r_duty2, r_duty1};

    // speed error and low-pass mix
    assign err_sum = 18'(in_left) + 18'(in_right) - 18'(r_target_speed);
    assign e22     = 22'(r_err);
    assign f22     = 22'(r_filt);
    assign mix     = (e22 <<< 1) + e22 + (f22 <<< 3) - f22;
    assign mix_neg = -mix;
    assign mix_abs = mix[21] ? mix_neg : mix;

    // divide by ten: reciprocal estimate and one correction
    assign quo_est = r_prod[41:24];
    assign quo10   = {1'b0, quo_est, 3'b0} + {3'b0, quo_est, 1'b0};
    assign rem     = {1'b0, r_mix_abs} - quo10;
    assign fq      = $signed({1'b0, r_quo});
    assign fv      = r_mix_neg ? -fq : fq;

    assign r_integ_ext = 19'(r_integ);
    assign integ_sum   = r_integ_ext + 19'(r_filt);

    // q33.8 to integer, toward zero
    assign acc_adj = r_acc + (r_acc[40] ? 41'sd255 : 41'sd0);
    assign acc_q   = acc_adj >>> 8;
    assign spout_c = (acc_q > SAT_HI) ? 16'sd32767 :
                     (acc_q < SAT_LO) ? -16'sd32767 : acc_q[15:0];

    assign sp17 = 17'(r_spout) + 17'(r_mid_angle);
    assign aerr = 26'(r_angle) - 26'($signed({sp17, 8'b0}));

    assign mag_w     = acc_q[40] ? -acc_q : acc_q;
    assign mag_c     = (mag_w > DLIM) ? DLIM : mag_w;
    assign duty2_sum = mag_c[16:0] + 17'(SECOND_OFFSET);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_DIV: begin
                mul_a = $signed({5'b0, r_mix_abs});
                mul_b = $signed({1'b0, DIV10_RECIP});
            end
            S_PKP: begin
                mul_a = 26'(r_filt);
                mul_b = 22'(r_speed_kp);
            end
            S_PKI: begin
                mul_a = 26'(r_integ);
                mul_b = 22'(r_speed_ki);
            end
            S_UKP: begin
                mul_a = r_aerr;
                mul_b = 22'(r_upright_kp);
            end
            S_UKD: begin
                mul_a = 26'(r_rate);
                mul_b = 22'(r_upright_kd);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = S_MIX;
            S_MIX:    n_state = S_DIV;
            S_DIV:    n_state = S_DIVFIX;
            S_DIVFIX: n_state = S_FILT;
            S_FILT:   n_state = S_PKP;
            S_PKP:    n_state = S_PKI;
            S_PKI:    n_state = S_PSUM;
            S_PSUM:   n_state = S_PSAT;
            S_PSAT:   n_state = S_UERR;
            S_UERR:   n_state = S_UKP;
            S_UKP:    n_state = S_UKD;
            S_UKD:    n_state = S_USUM;
            S_USUM:   n_state = S_DRV;
            S_DRV:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_speed <= '0;
            r_mid_angle    <= '0;
            r_upright_kp   <= '0;
            r_upright_kd   <= '0;
            r_speed_kp     <= '0;
            r_speed_ki     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TARGET_SPEED: r_target_speed <= i_cfg_data;
                CFG_MID_ANGLE:    r_mid_angle    <= i_cfg_data[7:0];
                CFG_UPRIGHT_KP:   r_upright_kp   <= i_cfg_data[12:0];
                CFG_UPRIGHT_KD:   r_upright_kd   <= i_cfg_data;
                CFG_SPEED_KP:     r_speed_kp     <= i_cfg_data;
                CFG_SPEED_KI:     r_speed_ki     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // loop state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FILT) begin
                r_filt <= fv[17:0];
            end
            if (r_state == S_PKP) begin
                if (integ_sum > ILIM) begin
                    r_integ <= ILIM[14:0];
                end else if (integ_sum < ILIM_NEG) begin
                    r_integ <= ILIM_NEG[14:0];
                end else begin
                    r_integ <= integ_sum[14:0];
                end
            end
            if (r_state == S_DRV && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_acc) begin
            r_angle <= in_angle;
            r_rate  <= in_rate;
            r_err   <= err_sum;
        end
        unique case (r_state)
            S_MIX: begin
                r_mix_neg <= mix[21];
                r_mix_abs <= mix_abs[20:0];
            end
            S_DIVFIX: r_quo <= (rem >= 22'd10) ? quo_est + 18'd1 : quo_est;
            S_PKI:    r_acc <= r_prod[40:0];
            S_PSUM:   r_acc <= r_acc + $signed(r_prod[40:0]);
            S_PSAT:   r_spout <= spout_c;
            S_UERR:   r_aerr <= aerr;
            S_UKD:    r_acc <= r_prod[40:0];
            S_USUM:   r_acc <= r_acc + $signed(r_prod[40:0]);
            S_DRV: begin
                if (out_free) begin
                    r_duty1     <= mag_c[12:0];
                    r_duty2     <= duty2_sum[12:0];
                    r_dir       <= acc_q[40];
                    r_out_spout <= r_spout;
                end
            end
            default: ;
        endcase
    end

    `BCC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> !o_s_axis_tready)
    `BCC_ASSERT(a_integ_range, i_clk, i_rst_n, (r_integ_ext <= ILIM) && (r_integ_ext >= ILIM_NEG))
    `BCC_ASSERT(a_duty_offset, i_clk, i_rst_n, o_m_axis_tvalid |-> (r_duty2 == 13'(r_duty1 + 13'(SECOND_OFFSET))))
    `BCC_ASSERT(a_drv_loads, i_clk, i_rst_n, (r_state == S_DRV && out_free) |=> (o_m_axis_tvalid && o_s_axis_tready))

endmodule
